// ===== hw/rtl/fixed_slot_pool_allocator_unit_defines.svh =====
// Assertion macros shared by the fixed slot pool allocator RTL.
`ifndef FIXED_SLOT_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FSPA_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fixed slot pool allocator: assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FSPA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fixed slot pool allocator: assertion failed");

`endif

// ===== hw/rtl/fspa_pkg.sv =====
// Package with the types and constants of the fixed slot pool allocator.
package fspa_pkg;

   localparam int CHUNK_BITS = 16;
   localparam int POS_W      = 4;
   localparam int FREE_W     = 9;
   localparam int ID_W       = 32;
   localparam int ADDR_W     = 64;
   localparam int BYTES_W    = 32;
   localparam int GRANT_W    = 8;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_SLOT_BYTES   = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_SLOT_COUNT   = 2'd2;

   typedef enum logic {
      OP_ACQUIRE = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_RETRY   = 2'd1,
      ST_IGNORED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MUL,
      S_ADD,
      S_REL,
      S_FIN
   } state_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] pos;
   } find_type;

endpackage

// ===== hw/rtl/fspa_find.sv =====
// Lowest-free-bit finder over one chunk of the busy map.
module fspa_find (
   input  logic [fspa_pkg::CHUNK_BITS-1:0] busy_word,
   output fspa_pkg::find_type              result
);
   import fspa_pkg::*;

   // Walk from the top down so the lowest free bit is the one that sticks.
   always_comb begin
      result.found = 1'b0;
      result.pos   = '0;
      for (int j = CHUNK_BITS - 1; j >= 0; j--) begin
         if (!busy_word[j]) begin
            result.found = 1'b1;
            result.pos   = POS_W'(j);
         end
      end
   end

endmodule

// ===== hw/rtl/fixed_slot_pool_allocator_unit.sv =====
// Top level of the fixed slot pool allocator: registers, sequencer and busy map.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_op, req_slot_id
//   rsp      out        rsp_valid / rsp_stall  rsp_status, rsp_granted_slot,
//                                              rsp_slot_address, rsp_capacity,
//                                              rsp_free_count
//   csr      in         psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// A release passes through the check state S_REL and the finish state S_FIN, then the
// block returns to idle, where the next request is taken; its response is registered
// in S_FIN. An acquire passes through S_SCAN, S_MUL, S_ADD and S_FIN: the sequencer
// scans the busy map one 16-slot chunk per cycle through a single priority finder,
// then multiplies slot by slot size in S_MUL and adds the base in S_ADD. An acquire
// with no free slot goes straight to S_FIN and answers retry without scanning.
// Synchronous reset frees every slot and loads the register reset values.
// A finished response waits in the output register while rsp_stall is high;
// the block may accept and work on the next request meanwhile.
`include "fixed_slot_pool_allocator_unit_defines.svh"

module fixed_slot_pool_allocator_unit #(
   parameter int MAX_SLOTS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic [fspa_pkg::ID_W-1:0]           req_slot_id,
   // Response channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output fspa_pkg::status_type                rsp_status,
   output logic [fspa_pkg::GRANT_W-1:0]        rsp_granted_slot,
   output logic [fspa_pkg::ADDR_W-1:0]         rsp_slot_address,
   output logic [fspa_pkg::BYTES_W-1:0]        rsp_capacity,
   output logic [fspa_pkg::FREE_W-1:0]         rsp_free_count,
   // Configuration port.
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fspa_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [fspa_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [fspa_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import fspa_pkg::*;

   // The busy map is held as chunks of 16 slots; the scan reads one chunk a cycle.
   localparam int NCHUNK  = (MAX_SLOTS + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int CHUNK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int IDX_W   = CHUNK_W + POS_W;
   localparam int PROD_W  = IDX_W + BYTES_W;
   // The slot count register is 9 bits wide, so the active count never exceeds 511.
   localparam int ACT_CAP = (MAX_SLOTS > 511) ? 511 : MAX_SLOTS;

   localparam logic [BYTES_W-1:0]    SLOT_BYTES_RESET = 32'd4096;
   localparam logic [FREE_W-1:0]     SLOT_COUNT_RESET = 9'd256;

   state_type                  state_ff, state_in;
   op_type                     op_ff, op_in;
   logic [ID_W-1:0]            id_ff, id_in;
   logic [CHUNK_W-1:0]         chunk_ff, chunk_in;
   logic [IDX_W-1:0]           slot_ff, slot_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [ADDR_W-1:0]          addr_ff, addr_in;
   status_type                 status_ff, status_in;
   logic [CHUNK_BITS-1:0]      busy_ff [NCHUNK];
   logic [CHUNK_BITS-1:0]      busy_in [NCHUNK];
   logic [FREE_W-1:0]          free_ff, free_in;

   logic [ADDR_W-1:0]          base_ff, base_in;
   logic [BYTES_W-1:0]         bytes_ff, bytes_in;
   logic [FREE_W-1:0]          count_ff, count_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   status_type                 rsp_status_ff, rsp_status_in;
   logic [GRANT_W-1:0]         rsp_granted_ff, rsp_granted_in;
   logic [ADDR_W-1:0]          rsp_addr_ff, rsp_addr_in;
   logic [BYTES_W-1:0]         rsp_cap_ff, rsp_cap_in;
   logic [FREE_W-1:0]          rsp_free_ff, rsp_free_in;

   logic [FREE_W-1:0]          active_count;
   logic [CHUNK_W-1:0]         rd_chunk;
   logic [CHUNK_BITS-1:0]      rd_word;
   find_type                   find;
   logic                       cfg_write;
   logic                       in_range;
   logic                       grant_ok;

   // Saturate a slot count at the built depth.
   function automatic logic [FREE_W-1:0] clamp_count(input logic [FREE_W-1:0] n);
      clamp_count = (n > FREE_W'(ACT_CAP)) ? FREE_W'(ACT_CAP) : n;
   endfunction

   assign active_count = clamp_count(count_ff);
   assign cfg_write    = psel && penable && pwrite && pready;
   assign pready       = 1'b1;

   // One read port on the busy map, shared by the scan and the release check.
   assign rd_chunk = (state_ff == S_SCAN) ? chunk_ff : id_ff[POS_W +: CHUNK_W];
   assign rd_word  = busy_ff[rd_chunk];
   assign in_range = id_ff < ID_W'(active_count);

   fspa_find u_find (
      .busy_word (rd_word),
      .result    (find)
   );

   // Register readback.
   always_comb begin
      case (paddr[CSR_ADDR_W-1 -: REG_IDX_W])
         REG_BASE_ADDRESS: prdata = base_ff;
         REG_SLOT_BYTES:   prdata = CSR_DATA_W'(bytes_ff);
         REG_SLOT_COUNT:   prdata = CSR_DATA_W'(count_ff);
         default:          prdata = '0;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign grant_ok  = (status_ff == ST_OK) && (op_ff == OP_ACQUIRE);

   // Sequencer: next state, datapath registers, busy map and response register.
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      id_in          = id_ff;
      chunk_in       = chunk_ff;
      slot_in        = slot_ff;
      prod_in        = prod_ff;
      addr_in        = addr_ff;
      status_in      = status_ff;
      busy_in        = busy_ff;
      free_in        = free_ff;
      base_in        = base_ff;
      bytes_in       = bytes_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_cap_in     = rsp_cap_ff;
      rsp_free_in    = rsp_free_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = op_type'(req_op);
               id_in    = req_slot_id;
               chunk_in = '0;
               if (op_type'(req_op) == OP_RELEASE) begin
                  state_in = S_REL;
               end else if (free_ff == '0) begin
                  // Nothing free: answer retry without touching the map.
                  status_in = ST_RETRY;
                  state_in  = S_FIN;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // A free slot is known to exist below the active count, and every
            // slot above it is free, so the first free bit found is the answer.
            if (find.found) begin
               slot_in                     = {chunk_ff, find.pos};
               busy_in[chunk_ff][find.pos] = 1'b1;
               free_in                     = free_ff - FREE_W'(1);
               state_in                    = S_MUL;
            end else begin
               chunk_in = chunk_ff + CHUNK_W'(1);
            end
         end
         S_MUL: begin
            prod_in  = PROD_W'(slot_ff) * PROD_W'(bytes_ff);
            state_in = S_ADD;
         end
         S_ADD: begin
            addr_in   = base_ff + ADDR_W'(prod_ff);
            status_in = ST_OK;
            state_in  = S_FIN;
         end
         S_REL: begin
            if (in_range && rd_word[id_ff[POS_W-1:0]]) begin
               busy_in[rd_chunk][id_ff[POS_W-1:0]] = 1'b0;
               free_in   = free_ff + FREE_W'(1);
               status_in = ST_OK;
            end else begin
               status_in = ST_IGNORED;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            // Load the response register once it is empty or being taken.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_granted_in = grant_ok ? GRANT_W'(slot_ff) : '0;
               rsp_addr_in    = grant_ok ? addr_ff : '0;
               rsp_cap_in     = grant_ok ? bytes_ff : '0;
               rsp_free_in    = free_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Configuration writes must arrive only while the block is idle; the block does not enforce it.
      if (cfg_write) begin
         case (paddr[CSR_ADDR_W-1 -: REG_IDX_W])
            REG_BASE_ADDRESS: base_in = pwdata;
            REG_SLOT_BYTES:   bytes_in = pwdata[BYTES_W-1:0];
            REG_SLOT_COUNT: begin
               // A new slot count frees the whole pool.
               count_in = pwdata[FREE_W-1:0];
               free_in  = clamp_count(pwdata[FREE_W-1:0]);
               for (int c = 0; c < NCHUNK; c++) begin
                  busy_in[c] = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         bytes_ff     <= SLOT_BYTES_RESET;
         count_ff     <= SLOT_COUNT_RESET;
         free_ff      <= clamp_count(SLOT_COUNT_RESET);
         for (int c = 0; c < NCHUNK; c++) begin
            busy_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         bytes_ff     <= bytes_in;
         count_ff     <= count_in;
         free_ff      <= free_in;
         busy_ff      <= busy_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      id_ff          <= id_in;
      chunk_ff       <= chunk_in;
      slot_ff        <= slot_in;
      prod_ff        <= prod_in;
      addr_ff        <= addr_in;
      status_ff      <= status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_cap_ff     <= rsp_cap_in;
      rsp_free_ff    <= rsp_free_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_slot = rsp_granted_ff;
   assign rsp_slot_address = rsp_addr_ff;
   assign rsp_capacity     = rsp_cap_ff;
   assign rsp_free_count   = rsp_free_ff;

   // The free count can never exceed the number of active slots.
   `FSPA_ASSERT_IMPL(a_free_within_active, 1'b1, free_ff <= active_count)
   // An accepted request always starts the sequencer.
   `FSPA_ASSERT_NEXT(a_accept_starts_work, req_valid && !req_stall, state_ff != S_IDLE)
   // The scan only runs with a free slot present and stays inside the map.
   `FSPA_ASSERT_IMPL(a_scan_bounded, state_ff == S_SCAN, (free_ff != '0) && (32'(chunk_ff) < NCHUNK))
   // A retry response reports an empty pool.
   `FSPA_ASSERT_IMPL(a_retry_when_empty, rsp_valid_ff && (rsp_status_ff == ST_RETRY), rsp_free_ff == '0)

endmodule

// ===== sim/fixed_slot_pool_allocator_unit_test.sv =====
// Self-checking testbench for the fixed slot pool allocator with a predicting scoreboard.
module fixed_slot_pool_allocator_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fspa_pkg::*;

   // The pool depth the block is built with; the predictor keeps one flag per slot.
   localparam int POOL_DEPTH = 256;

   // Register index that decodes to no register; a write there must change nothing.
   localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

   // Cycles without any accepted request, response or register write before the
   // run is declared hung. The longest legal quiet stretch is the receiver's long
   // hold-off.
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 40;
   localparam int PHASES           = 12;

   // One response as the block is expected to return it.
   typedef struct {
      status_type               status;
      logic [GRANT_W-1:0]       granted;
      logic [ADDR_W-1:0]        address;
      logic [BYTES_W-1:0]       capacity;
      logic [FREE_W-1:0]        free_count;
   } slot_response_type;

   // Scoreboard: keeps its own copy of the busy map, the free counter and the
   // three registers, predicts the response of every accepted request and
   // compares each accepted response with the oldest prediction.
   class slot_pool_scoreboard;
      bit                 slot_taken [POOL_DEPTH];
      logic [FREE_W-1:0]  free_total;
      logic [ADDR_W-1:0]  pool_base;
      logic [BYTES_W-1:0] pool_slot_bytes;
      logic [FREE_W-1:0]  pool_slot_count;
      slot_response_type  expected_responses [$];
      int unsigned        errors;
      int unsigned        results_seen;
      int unsigned        grants;
      int unsigned        retries;
      int unsigned        ignored_releases;

      function new();
         pool_base       = '0;
         pool_slot_bytes = 32'd4096;
         pool_slot_count = 9'd256;
         clear_pool();
      endfunction

      // Slot counts above the built depth saturate at the depth.
      function int unsigned active_slots();
         return (pool_slot_count > POOL_DEPTH) ? POOL_DEPTH : pool_slot_count;
      endfunction

      function void clear_pool();
         foreach (slot_taken[k]) slot_taken[k] = 1'b0;
         free_total = FREE_W'(active_slots());
      endfunction

      function void write_register(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_BASE_ADDRESS: pool_base = value;
            REG_SLOT_BYTES:   pool_slot_bytes = value[BYTES_W-1:0];
            REG_SLOT_COUNT: begin
               // A new slot count starts the pool over with every slot free.
               pool_slot_count = value[FREE_W-1:0];
               clear_pool();
            end
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_responses.size();
      endfunction

      // Random busy (or free) slot inside the active range, or -1 if there is none.
      function int pick_slot(bit want_busy);
         int          candidates [$];
         int unsigned k;
         for (k = 0; k < active_slots(); k++)
            if (slot_taken[k] == want_busy) candidates.push_back(k);
         if (candidates.size() == 0) return -1;
         return candidates[$urandom_range(0, candidates.size() - 1)];
      endfunction

      function void note_request(op_type op, logic [ID_W-1:0] id);
         slot_response_type outcome;
         int unsigned       n;
         int unsigned       k;
         int unsigned       winner;
         bit                found;
         n                  = active_slots();
         found              = 1'b0;
         winner             = 0;
         outcome.status     = ST_OK;
         outcome.granted    = '0;
         outcome.address    = '0;
         outcome.capacity   = '0;
         if (op == OP_ACQUIRE) begin
            for (k = 0; k < n && !found; k++)
               if (!slot_taken[k]) begin
                  found  = 1'b1;
                  winner = k;
               end
            if (found) begin
               slot_taken[winner] = 1'b1;
               free_total         = free_total - 1'b1;
               outcome.granted    = winner[GRANT_W-1:0];
               outcome.address    = pool_base + 64'(winner) * 64'(pool_slot_bytes);
               outcome.capacity   = pool_slot_bytes;
               grants++;
            end else begin
               outcome.status = ST_RETRY;
               retries++;
            end
         end else begin
            if (id >= n || !slot_taken[id[7:0]]) begin
               outcome.status = ST_IGNORED;
               ignored_releases++;
            end else begin
               slot_taken[id[7:0]] = 1'b0;
               free_total          = free_total + 1'b1;
            end
         end
         outcome.free_count = free_total;
         expected_responses.push_back(outcome);
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_response(status_type status, logic [GRANT_W-1:0] granted,
                                   logic [ADDR_W-1:0] address, logic [BYTES_W-1:0] capacity,
                                   logic [FREE_W-1:0] free_count);
         slot_response_type want;
         results_seen++;
         if (expected_responses.size() == 0) begin
            $display("%0t ns: response with no request outstanding, expected none, got status %0d",
                     $time, status);
            errors++;
            return;
         end
         want = expected_responses.pop_front();
         compare_field("status", 64'(want.status), 64'(status));
         compare_field("granted_slot", 64'(want.granted), 64'(granted));
         compare_field("slot_address", want.address, address);
         compare_field("capacity", 64'(want.capacity), 64'(capacity));
         compare_field("free_count", 64'(want.free_count), 64'(free_count));
      endfunction
   endclass

   // Clock, reset and every block input start at known values.
   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   logic                   req_op      = 1'b0;
   logic [ID_W-1:0]        req_slot_id = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   status_type             rsp_status;
   logic [GRANT_W-1:0]     rsp_granted_slot;
   logic [ADDR_W-1:0]      rsp_slot_address;
   logic [BYTES_W-1:0]     rsp_capacity;
   logic [FREE_W-1:0]      rsp_free_count;
   logic                   psel        = 1'b0;
   logic                   penable     = 1'b0;
   logic                   pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0]  paddr       = '0;
   logic [CSR_DATA_W-1:0]  pwdata      = '0;
   logic [CSR_DATA_W-1:0]  prdata;
   logic                   pready;

   slot_pool_scoreboard    sb;

   // Per-phase switches: when clear, the matching side never idles, which gives
   // stretches of back-to-back traffic.
   bit                     req_idle_on = 1'b1;
   bit                     rsp_idle_on = 1'b1;
   bit                     long_hold_done = 1'b0;
   int unsigned            settings_applied = 0;
   int unsigned            idle_cycles = 0;

   // Slot counts visited by the random phases: the full pool, a single slot,
   // sizes around a 16-slot chunk boundary, and a value above the built depth.
   int unsigned            pool_sizes [PHASES] =
      '{256, 1, 3, 16, 17, 64, 255, 2, 511, 40, 8, 100};

   fixed_slot_pool_allocator_unit #(
      .MAX_SLOTS(POOL_DEPTH)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_slot_id     (req_slot_id),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_granted_slot(rsp_granted_slot),
      .rsp_slot_address(rsp_slot_address),
      .rsp_capacity    (rsp_capacity),
      .rsp_free_count  (rsp_free_count),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Offers one request after a random gap and holds it until the block takes it.
   // With no gap, valid simply stays high from the previous request.
   task automatic send_request(op_type op, logic [ID_W-1:0] id);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_slot_id <= id;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, id);
   endtask

   // Drops valid and waits until every outstanding request has been answered,
   // so the block is idle before its registers change.
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // One register write: an idle cycle, the setup cycle, then the access cycle.
   task automatic write_csr(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_register(idx, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Random traffic is mostly well formed: acquires and releases of slots that
   // are really held. About one request in ten is a bad release: a random
   // 32-bit id, a free slot, the first id past the active range, or a held
   // slot with high bits set so that its low byte aliases a busy entry.
   task automatic offer_random_request(int unsigned acquire_pct);
      int unsigned     roll;
      int              pick;
      op_type          op;
      logic [ID_W-1:0] id;
      roll = $urandom_range(0, 99);
      id   = $urandom();
      op   = OP_ACQUIRE;
      if (roll >= acquire_pct && roll < 90) begin
         pick = sb.pick_slot(1'b1);
         if (pick >= 0) begin
            op = OP_RELEASE;
            id = pick;
         end
      end else if (roll >= 90) begin
         op = OP_RELEASE;
         case ($urandom_range(0, 3))
            0: ;
            1: begin
               pick = sb.pick_slot(1'b0);
               if (pick >= 0) id = pick;
            end
            2: id = sb.active_slots();
            default: begin
               pick = sb.pick_slot(1'b1);
               if (pick >= 0) id = 32'(pick) | (32'h1 << $urandom_range(8, 31));
            end
         endcase
      end
      send_request(op, id);
   endtask

   // Every response the receiver takes is checked at the edge it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_status, rsp_granted_slot, rsp_slot_address,
                           rsp_capacity, rsp_free_count);
   end

   // Receiver: while rsp_idle_on is set it may stall before each response. Once, after a
   // few hundred responses, it holds off for LONG_HOLD_CYCLES so the block's
   // output register fills and the block pushes back on the sender.
   initial begin
      int unsigned hold;
      wait (!reset);
      forever begin
         if (!long_hold_done && sb.results_seen >= 300) begin
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            hold = rsp_idle_on ? $urandom_range(0, 3) : 0;
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Watchdog: ends the run if nothing at all is accepted for too long.
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Watchdog: no traffic for %0d cycles, %0d responses still due",
               WATCHDOG_LIMIT, sb.pending());
      $display("fixed_slot_pool_allocator_unit_test: FAIL");
      $finish;
   end

   initial begin
      int unsigned           phase;
      int unsigned           acquire_pct;
      logic [ADDR_W-1:0]     base_value;
      logic [BYTES_W-1:0]    bytes_value;

      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Out of reset the pool has 256 free slots of 4096 bytes at
      // address zero. Acquires hand out the lowest free slot; the id of an
      // acquire is don't-care, so one carries all ones.
      send_request(OP_ACQUIRE, '0);
      send_request(OP_ACQUIRE, '1);
      send_request(OP_ACQUIRE, '0);
      // Releasing a held slot frees it, a second release of it is ignored, and
      // the next acquire refills the hole below the others.
      send_request(OP_RELEASE, 32'd1);
      send_request(OP_RELEASE, 32'd1);
      send_request(OP_ACQUIRE, '0);
      // Releases past the active range are ignored, including one whose low
      // byte matches a slot that is really held; the last one frees held slot 2.
      send_request(OP_RELEASE, '1);
      send_request(OP_RELEASE, 32'd256);
      send_request(OP_RELEASE, 32'h0000_0102);
      send_request(OP_RELEASE, 32'd2);

      // Changing base and slot size keeps the busy map. With both at all ones
      // the slot address wraps around the 64-bit space.
      wait_for_responses();
      write_csr(REG_BASE_ADDRESS, '1);
      write_csr(REG_SLOT_BYTES, '1);
      send_request(OP_ACQUIRE, '0);
      send_request(OP_ACQUIRE, '0);

      // A zero slot size maps every slot to the base and reports no capacity.
      wait_for_responses();
      write_csr(REG_SLOT_BYTES, '0);
      send_request(OP_ACQUIRE, '0);

      // A write to the unused register index changes nothing.
      wait_for_responses();
      write_csr(REG_UNUSED, '1);
      send_request(OP_ACQUIRE, '0);

      // A two-slot pool: the third acquire must retry, then a release past the
      // end is ignored and a freed slot is handed out again.
      wait_for_responses();
      write_csr(REG_SLOT_BYTES, 32'd64);
      write_csr(REG_SLOT_COUNT, 64'd2);
      send_request(OP_ACQUIRE, '0);
      send_request(OP_ACQUIRE, '0);
      send_request(OP_ACQUIRE, '0);
      send_request(OP_RELEASE, 32'd1);
      send_request(OP_RELEASE, 32'd2);
      send_request(OP_ACQUIRE, '0);

      // No slots at all: every acquire retries and every release is ignored.
      wait_for_responses();
      write_csr(REG_SLOT_COUNT, 64'd0);
      send_request(OP_ACQUIRE, '0);
      send_request(OP_RELEASE, 32'd0);

      // Random phases. Each one picks a base and slot size, usually starts the
      // pool over with a new slot count, and sets how often each side idles.
      // The first phase is acquire heavy on the full pool so that it fills and
      // the retry path runs with every slot taken.
      for (phase = 0; phase < PHASES; phase++) begin
         wait_for_responses();
         case ($urandom_range(0, 3))
            0:       base_value = '0;
            1:       base_value = '1;
            2:       base_value = {$urandom(), $urandom()};
            default: base_value = {32'hFFFF_FFFF, $urandom()};
         endcase
         case ($urandom_range(0, 4))
            0:       bytes_value = 32'd1;
            1:       bytes_value = '1;
            2:       bytes_value = $urandom();
            3:       bytes_value = '0;
            default: bytes_value = 32'd4096 << $urandom_range(0, 8);
         endcase
         write_csr(REG_BASE_ADDRESS, base_value);
         // The upper half of the bus carries noise that the register must drop.
         write_csr(REG_SLOT_BYTES, {$urandom(), bytes_value});
         if (phase == 0 || $urandom_range(0, 3) != 0)
            write_csr(REG_SLOT_COUNT, ({$urandom(), $urandom()} & ~64'h1FF) |
                      64'(pool_sizes[phase]));
         settings_applied++;
         req_idle_on = (phase % 4 != 3);
         rsp_idle_on = (phase % 4 != 3);
         acquire_pct = (phase == 0) ? 89 : $urandom_range(30, 80);
         repeat ((phase == 0) ? 300 : 55) offer_random_request(acquire_pct);
      end

      // Let everything drain, then give the block time to show any stray response.
      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d responses over %0d random pool settings plus directed cases:",
               sb.results_seen, settings_applied);
      $display("%0d slots granted, %0d retries, %0d releases ignored, %0d mismatches.",
               sb.grants, sb.retries, sb.ignored_releases, sb.errors);
      if (sb.errors == 0)
         $display("fixed_slot_pool_allocator_unit_test: PASS");
      else
         $display("fixed_slot_pool_allocator_unit_test: FAIL");
      $finish;
   end

endmodule

// ===== fixed_slot_pool_allocator_unit.f =====
+incdir+hw/rtl
hw/rtl/fspa_pkg.sv
hw/rtl/fspa_find.sv
hw/rtl/fixed_slot_pool_allocator_unit.sv
sim/fixed_slot_pool_allocator_unit_test.sv
